### rtl/core/mlr_pkg.sv
package mlr_pkg;

  // Field widths of the pixel interface.
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned COLOR_BITS = 24;

  // The decision value spans about -2*2^COORD_BITS .. 2*2^COORD_BITS, and the
  // increments need one bit less. Both keep a guard bit.
  localparam int unsigned DEC_BITS = COORD_BITS + 4;
  localparam int unsigned INC_BITS = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [DEC_BITS-1:0]   dec_t;
  typedef logic [INC_BITS-1:0]   inc_t;

  // Request codes of the input channel.
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_t;

  // One input transfer.
  typedef struct packed {
    mode_t  mode;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t line_color;
  } in_item_t;

  // One output transfer.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } out_item_t;

  // Line parameters derived from a start request.
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t major_end;
    dec_t   decision;
    inc_t   inc_no_step;
    inc_t   inc_with_step;
    logic   y_major;
    logic   minor_down;
  } line_setup_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic active;
    logic first_pending;
  } eng_status_t;

endpackage

### rtl/core/mlr_setup.sv
module mlr_setup (
  input  mlr_pkg::in_item_t    item,
  output mlr_pkg::line_setup_t setup
);

  mlr_pkg::coord_t adx;
  mlr_pkg::coord_t ady;
  mlr_pkg::coord_t dmaj;
  mlr_pkg::coord_t dmin;
  mlr_pkg::coord_t x0;
  mlr_pkg::coord_t y0;
  mlr_pkg::coord_t x1;
  mlr_pkg::coord_t y1;
  logic            y_major;
  logic            swap;

  always_comb begin
    // Spans of both axes; x is major when they are equal.
    adx     = (item.x_end >= item.x_start) ? item.x_end - item.x_start
                                           : item.x_start - item.x_end;
    ady     = (item.y_end >= item.y_start) ? item.y_end - item.y_start
                                           : item.y_start - item.y_end;
    y_major = ady > adx;

    // Order the endpoints so that the major coordinate increases.
    swap = y_major ? (item.y_end < item.y_start) : (item.x_end < item.x_start);
    x0   = swap ? item.x_end   : item.x_start;
    y0   = swap ? item.y_end   : item.y_start;
    x1   = swap ? item.x_start : item.x_end;
    y1   = swap ? item.y_start : item.y_end;

    dmaj = y_major ? ady : adx;
    dmin = y_major ? adx : ady;

    setup.x0         = x0;
    setup.y0         = y0;
    setup.major_end  = y_major ? y1 : x1;
    setup.y_major    = y_major;
    setup.minor_down = y_major ? (x1 < x0) : (y1 < y0);

    // Decision starts at dmaj - 2*dmin; increments are -2*dmin and 2*(dmaj - dmin).
    setup.decision      = mlr_pkg::DEC_BITS'(dmaj) - (mlr_pkg::DEC_BITS'(dmin) << 1);
    setup.inc_no_step   = mlr_pkg::INC_BITS'(0) - (mlr_pkg::INC_BITS'(dmin) << 1);
    setup.inc_with_step = (mlr_pkg::INC_BITS'(dmaj) - mlr_pkg::INC_BITS'(dmin)) << 1;
  end

endmodule

### rtl/core/mlr_engine.sv
module mlr_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  mlr_pkg::in_item_t    item,
  input  mlr_pkg::line_setup_t setup,
  output logic                 res_vld,
  output mlr_pkg::out_item_t   res,
  output mlr_pkg::eng_status_t status
);

  mlr_pkg::coord_t cur_x_r, cur_x_nxt;
  mlr_pkg::coord_t cur_y_r, cur_y_nxt;
  mlr_pkg::coord_t major_end_r, major_end_nxt;
  mlr_pkg::dec_t   decision_r, decision_nxt;
  mlr_pkg::inc_t   inc_no_step_r, inc_no_step_nxt;
  mlr_pkg::inc_t   inc_with_step_r, inc_with_step_nxt;
  mlr_pkg::color_t held_color_r, held_color_nxt;
  logic            y_major_r, y_major_nxt;
  logic            minor_down_r, minor_down_nxt;
  logic            first_pending_r, first_pending_nxt;
  logic            active_r, active_nxt;

  logic            move_minor;
  mlr_pkg::dec_t   inc_sel;
  mlr_pkg::coord_t major_pos;
  logic            is_last;

  // Next line state and the pixel of a step request.
  always_comb begin
    cur_x_nxt         = cur_x_r;
    cur_y_nxt         = cur_y_r;
    major_end_nxt     = major_end_r;
    decision_nxt      = decision_r;
    inc_no_step_nxt   = inc_no_step_r;
    inc_with_step_nxt = inc_with_step_r;
    held_color_nxt    = held_color_r;
    y_major_nxt       = y_major_r;
    minor_down_nxt    = minor_down_r;
    first_pending_nxt = first_pending_r;
    active_nxt        = active_r;
    res_vld           = 1'b0;

    // A zero decision value moves the minor axis.
    move_minor = decision_r[mlr_pkg::DEC_BITS-1] || (decision_r == '0);
    inc_sel    = move_minor
      ? {{(mlr_pkg::DEC_BITS-mlr_pkg::INC_BITS){inc_with_step_r[mlr_pkg::INC_BITS-1]}},
         inc_with_step_r}
      : {{(mlr_pkg::DEC_BITS-mlr_pkg::INC_BITS){inc_no_step_r[mlr_pkg::INC_BITS-1]}},
         inc_no_step_r};

    if (go) begin
      if (item.mode == mlr_pkg::MODE_START) begin
        // A start request replaces any line in progress and gives no pixel.
        cur_x_nxt         = setup.x0;
        cur_y_nxt         = setup.y0;
        major_end_nxt     = setup.major_end;
        decision_nxt      = setup.decision;
        inc_no_step_nxt   = setup.inc_no_step;
        inc_with_step_nxt = setup.inc_with_step;
        y_major_nxt       = setup.y_major;
        minor_down_nxt    = setup.minor_down;
        held_color_nxt    = item.line_color;
        first_pending_nxt = 1'b1;
        active_nxt        = 1'b1;
      end else if (active_r) begin
        res_vld = 1'b1;
        if (first_pending_r) begin
          // The start point goes out without a step.
          first_pending_nxt = 1'b0;
        end else begin
          decision_nxt = decision_r + inc_sel;
          if (y_major_r) begin
            cur_y_nxt = cur_y_r + mlr_pkg::COORD_BITS'(1);
            if (move_minor) begin
              cur_x_nxt = minor_down_r ? cur_x_r - mlr_pkg::COORD_BITS'(1)
                                       : cur_x_r + mlr_pkg::COORD_BITS'(1);
            end
          end else begin
            cur_x_nxt = cur_x_r + mlr_pkg::COORD_BITS'(1);
            if (move_minor) begin
              cur_y_nxt = minor_down_r ? cur_y_r - mlr_pkg::COORD_BITS'(1)
                                       : cur_y_r + mlr_pkg::COORD_BITS'(1);
            end
          end
        end
      end
    end

    // The line ends when the major coordinate reaches the end point.
    major_pos = y_major_r ? cur_y_nxt : cur_x_nxt;
    is_last   = major_pos == major_end_r;
    if (res_vld && is_last) begin
      active_nxt = 1'b0;
    end

    res.pixel_x     = cur_x_nxt;
    res.pixel_y     = cur_y_nxt;
    res.pixel_color = held_color_r;
    res.last_pixel  = is_last;

    status.active        = active_r;
    status.first_pending = first_pending_r;
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r         <= '0;
      cur_y_r         <= '0;
      major_end_r     <= '0;
      decision_r      <= '0;
      inc_no_step_r   <= '0;
      inc_with_step_r <= '0;
      held_color_r    <= '0;
      y_major_r       <= 1'b0;
      minor_down_r    <= 1'b0;
      first_pending_r <= 1'b0;
      active_r        <= 1'b0;
    end else begin
      cur_x_r         <= cur_x_nxt;
      cur_y_r         <= cur_y_nxt;
      major_end_r     <= major_end_nxt;
      decision_r      <= decision_nxt;
      inc_no_step_r   <= inc_no_step_nxt;
      inc_with_step_r <= inc_with_step_nxt;
      held_color_r    <= held_color_nxt;
      y_major_r       <= y_major_nxt;
      minor_down_r    <= minor_down_nxt;
      first_pending_r <= first_pending_nxt;
      active_r        <= active_nxt;
    end
  end

endmodule

### rtl/core/midpoint_line_rasterizer_core.sv
// A step request's pixel passes through the input register, then the result
// register, on its way to the output.
// Throughput: one request per cycle while the output does not stall; the line
// state updates through one decision add and a step of the coordinates.
// Reset (synchronous, active low): the block is idle, both registers empty.
module midpoint_line_rasterizer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mlr_pkg::out_item_t out_item
);

  logic                 in_vld_r;
  mlr_pkg::in_item_t    in_item_r;
  logic                 out_vld_r;
  mlr_pkg::out_item_t   out_item_r;

  logic                 in_xfer;
  logic                 advance;
  logic                 res_vld;
  mlr_pkg::out_item_t   res;
  mlr_pkg::line_setup_t setup;
  mlr_pkg::eng_status_t status;

  // The held request moves on whenever the result register is free or drains.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_item;
    end
  end

  mlr_setup u_setup (
    .item  (in_item_r),
    .setup (setup)
  );

  mlr_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (advance),
    .item    (in_item_r),
    .setup   (setup),
    .res_vld (res_vld),
    .res     (res),
    .status  (status)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res_vld;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // A new result only appears after a request moved into the engine.
  a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a request moving on");

  // A step request while idle gives no pixel.
  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.mode == mlr_pkg::MODE_STEP && !status.active) |=> !out_valid)
    else $error("step while idle produced a pixel");

  // The end point closes the line.
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_vld && res.last_pixel) |=> !status.active)
    else $error("line still active after its last pixel");

  // A start request arms the engine with the start point pending.
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.mode == mlr_pkg::MODE_START)
      |=> (status.active && status.first_pending))
    else $error("start request did not arm the line");

endmodule
